>>> rtl/aes_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes_pkg: shared types and constants of the sensor averager and scaler
// Slot layout, item and control structs, log2 table, per-channel constants.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int CHANNELS       = 4;
  localparam int SLOTS          = 2 * CHANNELS;
  localparam int SLOT_W         = $clog2(SLOTS);
  localparam int LOG_TABLE_BITS = 8;
  localparam int TAB_SIZE       = (1 << LOG_TABLE_BITS) + 1;
  localparam int REM_W          = 32 - LOG_TABLE_BITS;
  localparam int QDEPTH         = 2;
  localparam int QPTR_W         = $clog2(QDEPTH);
  localparam int QCNT_W         = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int DIV_NW         = 42;
  localparam int DIV_DW         = 34;
  localparam int DIV_STEPS      = DIV_NW / 2;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS + 1);

  localparam logic [15:0] WEIGHT_RESET = 16'd6554;
  localparam logic [14:0] ZSTART_RESET = 15'd2667;
  localparam logic [14:0] ZFLOOR_RESET = 15'd1333;
  localparam logic [1:0]  THERM_CH     = 2'd2;
  localparam logic [1:0]  TRACK_CH     = 2'd3;

  // ceil(2^42 / 15625), exact quotient for every pressure numerator
  localparam logic [28:0] P_RECIP      = 29'd281474977;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WEIGHT = 2'd0,
    CFG_ZSTART = 2'd1,
    CFG_ZFLOOR = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ROLE_PRESS,
    ROLE_TRACK,
    ROLE_THERM
  } role_t;

  typedef struct packed {
    logic              dev;
    logic [1:0]        ch;
    logic signed [15:0] raw;
    logic [SLOT_W-1:0] slot;
    role_t             role;
  } item_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] numer;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quo;
  } div_rsp_t;

  typedef enum logic [4:0] {
    B_IDLE, B_EMA, B_LEVEL, B_CLASS, B_PNUM, B_PMUL, B_PDIV, B_PREC, B_PQ,
    B_LOGX, B_NORM, B_INTERP, B_LOGSUM, B_LN, B_SQ, B_CUBE,
    B_BLN, B_CCUBE, B_INV, B_NMUL, B_TDIV, B_DIVW, B_DONE
  } back_state_t;

  typedef logic [TAB_SIZE-1:0][16:0] log_tab_t;

  function automatic log_tab_t build_log_tab();
    log_tab_t    t;
    logic [63:0] m;
    logic [16:0] y;
    for (int i = 0; i < TAB_SIZE; i++) begin
      if (i == (1 << LOG_TABLE_BITS)) begin
        t[i] = 17'd65536;
      end else begin
        m = 64'((1 << LOG_TABLE_BITS) + i) << (30 - LOG_TABLE_BITS);
        y = '0;
        for (int k = 15; k >= 0; k--) begin
          m = (m * m) >> 30;
          if (m >= (64'd2 << 30)) begin
            m = m >> 1;
            y[k] = 1'b1;
          end
        end
        t[i] = y;
      end
    end
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

  function automatic role_t role_of(input logic dev, input logic [1:0] ch);
    if (ch == THERM_CH) return ROLE_THERM;
    if (!dev && ch == TRACK_CH) return ROLE_TRACK;
    return ROLE_PRESS;
  endfunction

  // scale in milli hPa per volt
  function automatic logic [22:0] press_k(input logic dev, input logic [1:0] ch);
    logic [2:0] sel;
    sel = {dev, ch};
    case (sel)
      3'b000:  return 23'd2500000;
      3'b001:  return 23'd258575;
      3'b011:  return 23'd1723690;
      3'b100:  return 23'd517000;
      3'b101:  return 23'd2585535;
      default: return 23'd258575;
    endcase
  endfunction

  function automatic logic [14:0] press_max(input logic dev, input logic [1:0] ch);
    logic [2:0] sel;
    sel = {dev, ch};
    case (sel)
      3'b000:  return 15'd10000;
      3'b001:  return 15'd1034;
      3'b011:  return 15'd6895;
      3'b100:  return 15'd2068;
      3'b101:  return 15'd10342;
      default: return 15'd1034;
    endcase
  endfunction

  function automatic logic signed [35:0] sh_a(input logic dev);
    return dev ? 36'sd15450000 : 36'sd15728000;
  endfunction

  function automatic logic signed [35:0] sh_b(input logic dev);
    return dev ? 36'sd2138000 : 36'sd2139000;
  endfunction

  function automatic logic signed [25:0] sh_c(input logic dev);
    return dev ? 26'sd2313 : 26'sd1682;
  endfunction

endpackage

`default_nettype wire

>>> rtl/aes_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes_if: sample and result channels
// Valid/ready channels carrying one item each.
// ----------------------------------------------------------------------------
interface aes_sample_if;
  logic              valid;
  logic              ready;
  logic              device;
  logic [1:0]        channel;
  logic signed [15:0] raw_count;

  modport source(output valid, device, channel, raw_count, input ready);
  modport sink(input valid, device, channel, raw_count, output ready);
endinterface

interface aes_result_if;
  logic              valid;
  logic              ready;
  logic              out_device;
  logic [1:0]        out_channel;
  logic signed [15:0] filtered_count;
  logic signed [14:0] value;
  logic              value_updated;
  logic [14:0]       zero_level;

  modport source(output valid, out_device, out_channel, filtered_count, value,
                 value_updated, zero_level, input ready);
  modport sink(input valid, out_device, out_channel, filtered_count, value,
               value_updated, zero_level, output ready);
endinterface

`default_nettype wire

>>> rtl/adc_sensor_ema_scaler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adc_sensor_ema_scaler: converter sample averager and sensor scaler
// Per-channel moving average, pressure scaling and thermistor conversion.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  sample    in   valid / ready      device, channel, raw_count
//  result    out  valid / ready      out_device .. zero_level
//  cfg       in   cfg_we             cfg_index, cfg_data
//
//  Pressure items skip the reciprocal division when the level is at or below
//  the offset; thermistor items wait on the divider and make two log2
//  normalizer passes; an open or shorted sensor skips the conversion.
//  A two-entry queue takes samples while the engine works; the result
//  register holds a finished item until taken. Synchronous reset, no
//  clearing pass.
// ----------------------------------------------------------------------------
module adc_sensor_ema_scaler (
  input  logic                            clk,
  input  logic                            rst,
  aes_sample_if.sink                      sample,
  aes_result_if.source                    result,
  input  logic                            cfg_we,
  input  logic [aes_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [aes_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import aes_pkg::*;

  cfg_wr_t  cfg;
  logic     push;
  item_t    push_item;
  logic     full;
  logic     pop_valid;
  logic     pop;
  item_t    pop_item;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  aes_front u_front (
    .sample    (sample),
    .full      (full),
    .push      (push),
    .push_item (push_item)
  );

  aes_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_item  (pop_item)
  );

  aes_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  aes_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop       (pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .result    (result)
  );

endmodule

`default_nettype wire

>>> rtl/aes_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes_front: sample intake
// Accepts samples, drops absent channels, tags slot and channel role.
// ----------------------------------------------------------------------------
module aes_front (
  aes_sample_if.sink      sample,
  input  logic            full,
  output logic            push,
  output aes_pkg::item_t  push_item
);
  import aes_pkg::*;

  logic ch_ok;

  assign ch_ok         = int'(sample.channel) < CHANNELS;
  assign sample.ready  = !full;
  assign push          = sample.valid && !full && ch_ok;

  always_comb begin
    push_item.dev  = sample.device;
    push_item.ch   = sample.channel;
    push_item.raw  = sample.raw_count;
    push_item.slot = SLOT_W'(sample.device) * SLOT_W'(CHANNELS) + SLOT_W'(sample.channel);
    push_item.role = role_of(sample.device, sample.channel);
  end

endmodule

`default_nettype wire

>>> rtl/aes_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes_queue: item queue
// Short queue between intake and the conversion engine.
// ----------------------------------------------------------------------------
module aes_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  aes_pkg::item_t  push_item,
  output logic            full,
  output logic            pop_valid,
  input  logic            pop,
  output aes_pkg::item_t  pop_item
);
  import aes_pkg::*;

  item_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = count == QCNT_W'(QDEPTH);
  assign pop_valid = count != '0;
  assign pop_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/aes_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes_div: unsigned divider
// Restoring division, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module aes_div (
  input  logic              clk,
  input  logic              rst,
  input  aes_pkg::div_req_t req,
  output aes_pkg::div_rsp_t rsp
);
  import aes_pkg::*;

  logic [DIV_DW:0]    rem;
  logic [DIV_NW-1:0]  q;
  logic [DIV_DW-1:0]  den;
  logic [DIV_CNT_W-1:0] cnt;
  logic               busy;
  logic               done;
  logic [DIV_DW:0]    r1;
  logic [DIV_DW:0]    r2;
  logic               b1;
  logic               b2;

  always_comb begin
    r1 = {rem[DIV_DW-1:0], q[DIV_NW-1]};
    b1 = r1 >= {1'b0, den};
    if (b1) r1 = r1 - {1'b0, den};
    r2 = {r1[DIV_DW-1:0], q[DIV_NW-2]};
    b2 = r2 >= {1'b0, den};
    if (b2) r2 = r2 - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      q   <= req.numer;
      den <= req.den;
    end else if (busy) begin
      rem <= r2;
      q   <= {q[DIV_NW-3:0], b1, b2};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = q;

endmodule

`default_nettype wire

>>> rtl/aes_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes_back: conversion engine
// Averages, then scales to pressure or converts thermistor to degrees.
// ----------------------------------------------------------------------------
module aes_back (
  input  logic              clk,
  input  logic              rst,
  input  aes_pkg::cfg_wr_t  cfg,
  input  logic              pop_valid,
  input  aes_pkg::item_t    pop_item,
  output logic              pop,
  output aes_pkg::div_req_t div_req,
  input  aes_pkg::div_rsp_t div_rsp,
  aes_result_if.source      result
);
  import aes_pkg::*;

  back_state_t st, st_next;
  item_t       itm;

  logic [15:0] weight;
  logic [14:0] zfloor;
  logic [14:0] tz;

  logic signed [31:0] levels [SLOTS];
  logic [SLOTS-1:0]   seen;

  logic signed [31:0] lvl;
  logic signed [15:0] fc;
  logic signed [61:0] prod;
  logic signed [35:0] num;
  logic [47:0]        w;
  logic [5:0]         e;
  logic               pass;
  logic [22:0]        l2n;
  logic [22:0]        l2d;
  logic signed [35:0] lnr;
  logic signed [35:0] cube;
  logic signed [35:0] acc;
  logic signed [35:0] inv;
  logic               neg;
  logic signed [14:0] val;
  logic               upd;
  logic [13:0]        plo;
  logic [42:0]        rhi;

  logic               rvalid;
  logic               rdev;
  logic [1:0]         rch;
  logic signed [15:0] rfc;
  logic signed [14:0] rval;
  logic               rupd;
  logic [14:0]        rzero;

  logic signed [35:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [31:0] lvl_rd;
  logic signed [33:0] ema_diff;
  logic signed [31:0] lvl_new;
  logic signed [32:0] fc_w;
  logic signed [33:0] t3;
  logic signed [35:0] xden;
  logic signed [61:0] sh16;
  logic signed [61:0] nn;
  logic signed [61:0] nmag;
  logic signed [35:0] tinv;
  logic [31:0]        frac;
  logic [LOG_TABLE_BITS-1:0] idx;
  logic [LOG_TABLE_BITS:0]   idx_hi;
  logic [REM_W-1:0]   rem;
  logic [16:0]        lo;
  logic [16:0]        hi;
  logic [22:0]        l2;
  logic               is_bad;
  logic               take_zero;
  logic               out_free;
  logic [DIV_NW-1:0]  q;
  logic [56:0]        rsum;
  logic [14:0]        pq;

  assign lvl_rd   = levels[itm.slot];
  assign ema_diff = 34'(signed'({itm.raw, 16'h0000})) - 34'(lvl_rd);
  assign lvl_new  = seen[itm.slot] ? lvl_rd + 32'(prod >>> 16) : {itm.raw, 16'h0000};
  assign fc_w     = 33'(lvl) + 33'sd32768;
  assign t3       = 34'(lvl) * 34'sd3;
  assign xden     = 36'sd5242880000 - 36'(t3);
  assign is_bad   = (t3 >= 34'sd5232394240) || (t3 <= 34'sd10485760);
  assign take_zero = (17'(fc_w[32:16]) < 17'(signed'({2'b00, tz})))
                  && (17'(fc_w[32:16]) >= 17'(signed'({2'b00, zfloor})));
  assign sh16     = prod >>> 16;
  assign frac     = w[46:15];
  assign idx      = frac[31:REM_W];
  assign idx_hi   = {1'b0, idx} + 1'b1;
  assign rem      = frac[REM_W-1:0];
  assign lo       = LOG_TAB[idx];
  assign hi       = LOG_TAB[idx_hi];
  assign l2       = 23'({e, 16'h0000}) + 23'(lo) + prod[REM_W+22:REM_W];
  assign tinv     = acc + 36'(sh16);
  assign nn       = 62'sd1000000000000 - prod;
  assign nmag     = nn[61] ? -nn : nn;
  assign out_free = !rvalid || result.ready;
  assign q        = div_rsp.quo;
  assign rsum     = {rhi, 14'h0000} + prod[56:0];
  assign pq       = rsum[56:42];

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= B_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next       = st;
    pop           = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    div_req.start = 1'b0;
    div_req.numer = '0;
    div_req.den   = '0;
    unique case (st)
      B_IDLE: begin
        if (pop_valid) begin
          pop     = 1'b1;
          st_next = B_EMA;
        end
      end
      B_EMA: begin
        mul_a   = 36'(ema_diff);
        mul_b   = {10'b0, weight};
        st_next = B_LEVEL;
      end
      B_LEVEL: st_next = B_CLASS;
      B_CLASS: begin
        if (itm.role == ROLE_THERM) begin
          mul_a   = 36'(lvl);
          mul_b   = 26'sd6600;
          st_next = is_bad ? B_DONE : B_LOGX;
        end else begin
          st_next = B_PNUM;
        end
      end
      B_PNUM: st_next = B_PMUL;
      B_PMUL: begin
        mul_a   = num;
        mul_b   = {3'b0, press_k(itm.dev, itm.ch)};
        st_next = (num <= 36'sd0) ? B_DONE : B_PDIV;
      end
      B_PDIV: begin
        mul_a   = 36'(P_RECIP);
        mul_b   = 26'(prod[53:40]);
        st_next = B_PREC;
      end
      B_PREC: begin
        mul_a   = 36'(P_RECIP);
        mul_b   = 26'(plo);
        st_next = B_PQ;
      end
      B_PQ: st_next = B_DONE;
      B_LOGX: st_next = B_NORM;
      B_NORM: begin
        if (w[47] || w == '0) begin
          st_next = B_INTERP;
        end
      end
      B_INTERP: begin
        mul_a   = 36'(rem);
        mul_b   = 26'(signed'({9'b0, hi})) - 26'(signed'({9'b0, lo}));
        st_next = B_LOGSUM;
      end
      B_LOGSUM: st_next = pass ? B_LN : B_LOGX;
      B_LN: begin
        mul_a   = 36'(signed'({1'b0, l2n})) - 36'(signed'({1'b0, l2d}));
        mul_b   = 26'sd45426;
        st_next = B_SQ;
      end
      B_SQ: begin
        mul_a   = 36'(sh16);
        mul_b   = 26'(sh16);
        st_next = B_CUBE;
      end
      B_CUBE: begin
        mul_a   = 36'(sh16);
        mul_b   = 26'(lnr);
        st_next = B_BLN;
      end
      B_BLN: begin
        mul_a   = sh_b(itm.dev);
        mul_b   = 26'(lnr);
        st_next = B_CCUBE;
      end
      B_CCUBE: begin
        mul_a   = cube;
        mul_b   = sh_c(itm.dev);
        st_next = B_INV;
      end
      B_INV: st_next = B_NMUL;
      B_NMUL: begin
        mul_a   = inv;
        mul_b   = 26'sd27315;
        st_next = B_TDIV;
      end
      B_TDIV: begin
        div_req.start = 1'b1;
        div_req.numer = DIV_NW'(nmag);
        div_req.den   = DIV_DW'(inv * 36'sd100);
        st_next       = B_DIVW;
      end
      B_DIVW: begin
        if (div_rsp.done) begin
          st_next = B_DONE;
        end
      end
      B_DONE: begin
        if (out_free) begin
          st_next = B_IDLE;
        end
      end
      default: st_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (st)
      B_IDLE: begin
        if (pop_valid) itm <= pop_item;
      end
      B_LEVEL: begin
        lvl                <= lvl_new;
        levels[itm.slot]   <= lvl_new;
      end
      B_CLASS: begin
        fc   <= fc_w[31:16];
        val  <= '0;
        upd  <= !(itm.role == ROLE_THERM && is_bad);
        pass <= 1'b0;
      end
      B_PNUM: begin
        if (itm.role == ROLE_TRACK) begin
          num <= 36'sd3 * (36'(lvl) - 36'(signed'({1'b0, tz, 16'h0000})));
        end else begin
          num <= 36'(t3) - 36'sd524288000;
        end
      end
      B_PDIV:  plo <= prod[39:26];
      B_PREC:  rhi <= prod[42:0];
      B_PQ: begin
        val <= (pq > press_max(itm.dev, itm.ch))
             ? signed'(press_max(itm.dev, itm.ch)) : signed'(pq);
      end
      B_LOGX: begin
        w <= pass ? 48'(unsigned'(xden)) : prod[47:0];
        e <= 6'd47;
      end
      B_NORM: begin
        if (w[47:40] == 8'h00 && w != '0) begin
          w <= {w[39:0], 8'h00};
          e <= e - 6'd8;
        end else if (!w[47] && w != '0) begin
          w <= {w[46:0], 1'b0};
          e <= e - 6'd1;
        end
      end
      B_LOGSUM: begin
        if (pass) begin
          l2d <= l2;
        end else begin
          l2n  <= l2;
          pass <= 1'b1;
        end
      end
      B_SQ:    lnr  <= 36'(sh16);
      B_BLN:   cube <= 36'(sh16);
      B_CCUBE: acc  <= sh_a(itm.dev) + 36'(sh16);
      B_INV:   inv  <= (tinv < 36'sd1) ? 36'sd1 : tinv;
      B_TDIV:  neg  <= nn[61];
      B_DIVW: begin
        if (div_rsp.done) begin
          if (neg) begin
            val <= (q > DIV_NW'(100)) ? -15'sd100 : -signed'(q[14:0]);
          end else begin
            val <= (q > DIV_NW'(400)) ? 15'sd400 : signed'(q[14:0]);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= WEIGHT_RESET;
      zfloor <= ZFLOOR_RESET;
      tz     <= ZSTART_RESET;
      seen   <= '0;
      rvalid <= 1'b0;
    end else begin
      if (cfg.we) begin
        case (cfg.index)
          CFG_WEIGHT: weight <= cfg.data;
          CFG_ZFLOOR: zfloor <= cfg.data[14:0];
          default: ;
        endcase
      end
      if (st == B_LEVEL) begin
        seen[itm.slot] <= 1'b1;
      end
      if (st == B_CLASS && itm.role == ROLE_TRACK && take_zero) begin
        tz <= fc_w[30:16];
      end else if (cfg.we && cfg.index == CFG_ZSTART) begin
        tz <= cfg.data[14:0];
      end
      if (st == B_DONE && out_free) begin
        rvalid <= 1'b1;
      end else if (result.ready) begin
        rvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st == B_DONE && out_free) begin
      rdev  <= itm.dev;
      rch   <= itm.ch;
      rfc   <= fc;
      rval  <= val;
      rupd  <= upd;
      rzero <= tz;
    end
  end

  assign result.valid          = rvalid;
  assign result.out_device     = rdev;
  assign result.out_channel    = rch;
  assign result.filtered_count = rfc;
  assign result.value          = rval;
  assign result.value_updated  = rupd;
  assign result.zero_level     = rzero;

endmodule

`default_nettype wire

>>> sim/adc_sensor_ema_scaler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adc_sensor_ema_scaler_tb: self-checking bench for the sample averager
// Drives tagged converter samples through random idle and stall bursts and
// register sweeps. A bit-exact model of the averaging, pressure scaling,
// zero tracking and thermistor conversion predicts every result, and the
// bench compares each result field by field.
// ----------------------------------------------------------------------------
module adc_sensor_ema_scaler_tb;
  import aes_pkg::*;

  localparam longint Q16       = 65536;
  localparam longint P_DEN     = 64'sd1048576000000;
  localparam int     TAB_N     = (1 << LOG_TABLE_BITS) + 1;
  localparam int     MAX_CYCLE = 1000000;

  typedef struct {
    logic              dev;
    logic [1:0]        ch;
    logic [15:0]       fcount;
    logic [14:0]       val;
    logic              upd;
    logic [14:0]       zlevel;
  } sensor_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  aes_sample_if smp ();
  aes_result_if res ();

  adc_sensor_ema_scaler u_top (
    .clk       (clk),
    .rst       (rst),
    .sample    (smp),
    .result    (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sensor_result_t pending_results[$];
  int             errors;
  int             cycles;
  int             hold_left;
  int             stall_left;
  bit             idle_on;

  longint         weight;
  longint         zero_start;
  longint         zero_floor;
  longint         avg_level[SLOTS];
  bit             avg_seen[SLOTS];
  longint         zero_now;
  longint         log2_tab[TAB_N];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLE) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void build_log2_tab();
    longint unsigned m;
    longint          y;
    for (int i = 0; i < TAB_N; i++) begin
      if (i == TAB_N - 1) begin
        log2_tab[i] = Q16;
      end else begin
        m = longint'((1 << LOG_TABLE_BITS) + i) << (30 - LOG_TABLE_BITS);
        y = 0;
        for (int k = 15; k >= 0; k--) begin
          m = (m * m) >> 30;
          if (m >= (64'd2 << 30)) begin
            m = m >> 1;
            y = y | (longint'(1) << k);
          end
        end
        log2_tab[i] = y;
      end
    end
  endfunction

  function automatic longint log2_fix(longint unsigned x);
    int              e;
    int              idx;
    longint unsigned frac;
    longint unsigned rem;
    longint unsigned lo;
    longint unsigned hi;
    e = 0;
    while (e < 63 && (x >> (e + 1)) != 0) e++;
    if (e >= 32) frac = (x >> (e - 32)) & 64'hFFFF_FFFF;
    else frac = (x << (32 - e)) & 64'hFFFF_FFFF;
    idx = int'(frac >> (32 - LOG_TABLE_BITS));
    rem = frac & ((64'd1 << (32 - LOG_TABLE_BITS)) - 1);
    lo  = log2_tab[idx];
    hi  = log2_tab[idx + 1];
    return longint'(e) * Q16 + longint'(lo + (((hi - lo) * rem) >> (32 - LOG_TABLE_BITS)));
  endfunction

  function automatic longint scale_pressure(longint num, longint kmilli, longint maxv);
    longint q;
    if (num <= 0) return 0;
    q = (num * kmilli) / P_DEN;
    return (q > maxv) ? maxv : q;
  endfunction

  function automatic bit thermistor_deg(longint lvl, logic dev, output longint deg);
    longint t3, l2n, l2d, lnr, sq, cube, inv, n, ca, cb, cc;
    deg = 0;
    t3 = 3 * lvl;
    if (t3 >= 79840 * Q16 || t3 <= 160 * Q16) return 1'b0;
    ca = dev ? 15450000 : 15728000;
    cb = dev ? 2138000 : 2139000;
    cc = dev ? 2313 : 1682;
    l2n  = log2_fix(6600 * lvl);
    l2d  = log2_fix(80000 * Q16 - t3);
    lnr  = ((l2n - l2d) * 45426) >>> 16;
    sq   = (lnr * lnr) >>> 16;
    cube = (sq * lnr) >>> 16;
    inv  = ca + ((cb * lnr) >>> 16) + ((cc * cube) >>> 16);
    if (inv < 1) inv = 1;
    n = (64'sd1000000000000 - 27315 * inv) / (100 * inv);
    if (n < -100) n = -100;
    if (n > 400) n = 400;
    deg = n;
    return 1'b1;
  endfunction

  function automatic sensor_result_t predict_sensor(logic dev, logic [1:0] ch,
                                                    logic signed [15:0] raw);
    sensor_result_t r;
    int             s;
    longint         lvl, fc, val, deg;
    bit             upd;
    s = int'(dev) * CHANNELS + int'(ch);
    if (!avg_seen[s]) begin
      avg_level[s] = longint'(raw) * Q16;
      avg_seen[s]  = 1'b1;
    end else begin
      avg_level[s] = avg_level[s] + ((weight * (longint'(raw) * Q16 - avg_level[s])) >>> 16);
    end
    lvl = avg_level[s];
    fc  = (lvl + 32768) >>> 16;
    upd = 1'b1;
    val = 0;
    if (ch == THERM_CH) begin
      upd = thermistor_deg(lvl, dev, deg);
      val = upd ? deg : 0;
    end else begin
      case ({dev, ch})
        3'b000: val = scale_pressure(3 * lvl - 8000 * Q16, 2500000, 10000);
        3'b001: val = scale_pressure(3 * lvl - 8000 * Q16, 258575, 1034);
        3'b011: begin
          if (fc < zero_now && fc >= zero_floor) zero_now = fc;
          val = scale_pressure(3 * (lvl - zero_now * Q16), 1723690, 6895);
        end
        3'b100: val = scale_pressure(3 * lvl - 8000 * Q16, 517000, 2068);
        3'b101: val = scale_pressure(3 * lvl - 8000 * Q16, 2585535, 10342);
        default: val = scale_pressure(3 * lvl - 8000 * Q16, 258575, 1034);
      endcase
    end
    r.dev    = dev;
    r.ch     = ch;
    r.fcount = fc[15:0];
    r.val    = val[14:0];
    r.upd    = upd;
    r.zlevel = zero_now[14:0];
    return r;
  endfunction

  initial begin
    res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 13);
      end
    end
  end

  always @(posedge clk) begin
    sensor_result_t e;
    if (!rst && res.valid && res.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no sample pending");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (res.out_device !== e.dev) begin
          $error("out_device exp %0d got %0d", e.dev, res.out_device); errors++;
        end
        if (res.out_channel !== e.ch) begin
          $error("out_channel exp %0d got %0d", e.ch, res.out_channel); errors++;
        end
        if (res.filtered_count !== e.fcount) begin
          $error("filtered_count exp %0d got %0d", $signed(e.fcount), res.filtered_count);
          errors++;
        end
        if (res.value !== e.val) begin
          $error("value exp %0d got %0d", $signed(e.val), res.value); errors++;
        end
        if (res.value_updated !== e.upd) begin
          $error("value_updated exp %0d got %0d", e.upd, res.value_updated); errors++;
        end
        if (res.zero_level !== e.zlevel) begin
          $error("zero_level exp %0d got %0d", e.zlevel, res.zero_level); errors++;
        end
      end
    end
  end

  task automatic send_sample(logic dev, logic [1:0] ch, logic signed [15:0] raw);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      smp.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    smp.valid     <= 1'b1;
    smp.device    <= dev;
    smp.channel   <= ch;
    smp.raw_count <= raw;
    do @(posedge clk); while (!smp.ready);
    pending_results.push_back(predict_sensor(dev, ch, raw));
  endtask

  task automatic drain();
    smp.valid <= 1'b0;
    @(posedge clk);
    wait (pending_results.size() == 0);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] data);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_WEIGHT: weight = data;
      CFG_ZSTART: begin
        zero_start = data[14:0];
        zero_now   = zero_start;
      end
      CFG_ZFLOOR: zero_floor = data[14:0];
      default: ;
    endcase
  endtask

  function automatic logic signed [15:0] pick_raw();
    case ($urandom_range(0, 9))
      0, 1:    return 16'($urandom);
      2:       return 16'($urandom_range(40, 70));
      3:       return 16'($urandom_range(26590, 26640));
      4:       return 16'($urandom_range(1200, 2800));
      default: return 16'($urandom_range(0, 27000));
    endcase
  endfunction

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) begin
      send_sample(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), pick_raw());
    end
  endtask

  task automatic test_directed();
    send_sample(1'b0, 2'd0, 16'sd32767);
    send_sample(1'b0, 2'd1, -16'sd32768);
    send_sample(1'b0, 2'd2, 16'sd53);
    send_sample(1'b1, 2'd2, 16'sd26614);
    send_sample(1'b0, 2'd3, 16'sd2000);
    send_sample(1'b1, 2'd0, 16'sd0);
    send_sample(1'b1, 2'd1, 16'sd2667);
    send_sample(1'b1, 2'd3, -16'sd1);
    send_sample(1'b0, 2'd2, 16'sd54);
    send_sample(1'b1, 2'd2, 16'sd26613);
    send_sample(1'b0, 2'd2, 16'sd10000);
    send_sample(1'b1, 2'd2, 16'sd20000);
    send_sample(1'b0, 2'd3, 16'sd1000);
    send_sample(1'b0, 2'd3, 16'sd1500);
    send_sample(1'b0, 2'd0, -16'sd32768);
    send_sample(1'b1, 2'd1, 16'sd32767);
    send_sample(1'b0, 2'd2, -16'sd32768);
    send_sample(1'b1, 2'd2, 16'sd32767);
  endtask

  task automatic test_register_sweep();
    write_reg(CFG_WEIGHT, 16'd65535);
    write_reg(CFG_ZSTART, 16'd32767);
    write_reg(CFG_ZFLOOR, 16'd0);
    send_random(80);
    write_reg(CFG_WEIGHT, 16'd0);
    write_reg(CFG_ZSTART, 16'd0);
    write_reg(CFG_ZFLOOR, 16'd32767);
    send_random(60);
    write_reg(CFG_WEIGHT, 16'($urandom_range(1, 65534)));
    write_reg(CFG_ZSTART, 16'd3000);
    write_reg(CFG_ZFLOOR, 16'd1500);
    send_random(80);
    write_reg(CFG_WEIGHT, 16'd32768);
    send_random(80);
    write_reg(CFG_WEIGHT, 16'd6554);
    write_reg(CFG_ZSTART, 16'd2667);
    write_reg(CFG_ZFLOOR, 16'd1333);
  endtask

  task automatic test_backpressure();
    drain();
    hold_left = 400;
    idle_on   = 1'b0;
    send_random(30);
    idle_on   = 1'b1;
  endtask

  task automatic test_random();
    send_random(750);
    idle_on = 1'b0;
    send_random(150);
  endtask

  initial begin
    errors     = 0;
    hold_left  = 0;
    stall_left = 0;
    idle_on    = 1'b1;
    weight     = 6554;
    zero_start = 2667;
    zero_floor = 1333;
    zero_now   = zero_start;
    for (int i = 0; i < SLOTS; i++) begin
      avg_level[i] = 0;
      avg_seen[i]  = 1'b0;
    end
    build_log2_tab();
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = CFG_WEIGHT;
    cfg_data      = '0;
    smp.valid     = 1'b0;
    smp.device    = 1'b0;
    smp.channel   = 2'd0;
    smp.raw_count = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_register_sweep();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
